FILE: hdl/hsv_pkg.sv
// Constants shared by the HSV to RGB converter pipeline.
package hsv_pkg;

  // Hue units: 64 per degree, so one 60-degree sector is 3840 units.
  localparam logic [14:0] HUE_SECTOR  = 15'd3840;
  localparam logic [14:0] HUE_PAIR    = 15'd7680;
  localparam logic [11:0] DIST_MAX    = 12'd3840;

  // Common denominator 255 * 3840 for the exact X channel.
  localparam logic [19:0] X_DEN       = 20'd979200;

  // floor(x / 255) for x below 2^16 is (x * 32897) >> 23.
  localparam logic [15:0] Z_RECIP     = 16'd32897;

  // floor(y / 3825) estimate is (y * 1122867) >> 32, low by at most one.
  localparam logic [20:0] X_RECIP     = 21'd1122867;
  localparam logic [11:0] X_DIV       = 12'd3825;

  localparam logic [7:0]  CHAN_FULL   = 8'd255;
  localparam logic [7:0]  ALPHA       = 8'hFF;

  // Sector codes; hue at or past 300 degrees folds into the last one.
  localparam logic [2:0]  SEC_RED_UP  = 3'd0;
  localparam logic [2:0]  SEC_GRN_DN  = 3'd1;
  localparam logic [2:0]  SEC_GRN_UP  = 3'd2;
  localparam logic [2:0]  SEC_BLU_DN  = 3'd3;
  localparam logic [2:0]  SEC_BLU_UP  = 3'd4;
  localparam logic [2:0]  SEC_RED_DN  = 3'd5;

endpackage

FILE: hdl/hsv_to_rgb_converter.sv
// HSV to packed ARGB converter: six register stages, one pixel per clock.
// A request taken at a clock edge shows on done and argb_word together, out of the last stage.
// Throughput: one request per cycle; busy is always low, the pipeline never stalls.
// The depth is set by the multiplier chain: s * dist, v times the X numerator, and the
// reciprocal multiplications that divide by 255 and by 3825.
// Reset (rst, synchronous) clears the stage valid bits, so no stray done follows it.
module hsv_to_rgb_converter import hsv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [14:0] hue,
  input  logic [7:0]  saturation,
  input  logic [7:0]  brightness,
  output logic        done,
  output logic [31:0] argb_word
);

  // Stage registers.
  logic        v1, v2, v3, v4, v5;
  logic [2:0]  sec1, sec2, sec3, sec4, sec5;
  logic [7:0]  val1, val2, val3, val4, val5;
  logic [7:0]  sat1;
  logic [11:0] dist1;
  logic [19:0] a2;
  logic [15:0] z2;
  logic [19:0] b3;
  logic [7:0]  zc3, zc4, zc5;
  logic [27:0] n4;
  logic [19:0] y5;
  logic [7:0]  q5;

  // Stage 1 logic: sector, and distance of hue from the middle of its 120-degree pair.
  logic [2:0]  sec_next;
  logic [14:0] t_mod;
  logic [11:0] dist_next;

  assign busy = 1'b0;

  always_comb begin
    priority if (hue >= 15'd19200) begin
      sec_next = SEC_RED_DN;
    end else if (hue >= 15'd15360) begin
      sec_next = SEC_BLU_UP;
    end else if (hue >= 15'd11520) begin
      sec_next = SEC_BLU_DN;
    end else if (hue >= 15'd7680) begin
      sec_next = SEC_GRN_UP;
    end else if (hue >= HUE_SECTOR) begin
      sec_next = SEC_GRN_DN;
    end else begin
      sec_next = SEC_RED_UP;
    end
  end

  always_comb begin
    priority if (hue >= 15'd30720) begin
      t_mod = hue - 15'd30720;
    end else if (hue >= 15'd23040) begin
      t_mod = hue - 15'd23040;
    end else if (hue >= 15'd15360) begin
      t_mod = hue - 15'd15360;
    end else if (hue >= HUE_PAIR) begin
      t_mod = hue - HUE_PAIR;
    end else begin
      t_mod = hue;
    end
    if (t_mod >= HUE_SECTOR) begin
      dist_next = t_mod[11:0] - DIST_MAX;
    end else begin
      dist_next = DIST_MAX - t_mod[11:0];
    end
  end

  // Stage 3 logic: zero channel as (v * (255 - s)) / 255 by reciprocal.
  logic [31:0] z_prod;
  assign z_prod = {16'd0, z2} * {16'd0, Z_RECIP};

  // Stage 5 logic: quotient estimate of (N >> 8) / 3825.
  logic [40:0] q_prod;
  assign q_prod = {21'd0, n4[27:8]} * {20'd0, X_RECIP};

  // Stage 6 logic: correct the estimate and place channels by sector.
  logic [19:0] q_back;
  logic [19:0] rem;
  logic [7:0]  xc;
  logic [7:0]  red, green, blue;

  assign q_back = {12'd0, q5} * {8'd0, X_DIV};
  assign rem    = y5 - q_back;
  assign xc     = (rem >= {8'd0, X_DIV}) ? q5 + 8'd1 : q5;

  always_comb begin
    unique case (sec5)
      SEC_RED_UP: begin
        red = val5; green = xc;   blue = zc5;
      end
      SEC_GRN_DN: begin
        red = xc;   green = val5; blue = zc5;
      end
      SEC_GRN_UP: begin
        red = zc5;  green = val5; blue = xc;
      end
      SEC_BLU_DN: begin
        red = zc5;  green = xc;   blue = val5;
      end
      SEC_BLU_UP: begin
        red = xc;   green = zc5;  blue = val5;
      end
      default: begin
        red = val5; green = zc5;  blue = xc;
      end
    endcase
  end

  // Valid bits travel with each request.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      done <= v5;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    // Stage 1: capture the request with its sector and hue distance.
    sec1  <= sec_next;
    dist1 <= dist_next;
    sat1  <= saturation;
    val1  <= brightness;

    // Stage 2: s * dist and v * (255 - s).
    sec2 <= sec1;
    val2 <= val1;
    a2   <= {12'd0, sat1} * {8'd0, dist1};
    z2   <= {8'd0, val1} * {8'd0, CHAN_FULL - sat1};

    // Stage 3: X numerator factor and the zero channel.
    sec3 <= sec2;
    val3 <= val2;
    b3   <= X_DEN - a2;
    zc3  <= z_prod[30:23];

    // Stage 4: full X numerator v * (255*3840 - s*dist).
    sec4 <= sec3;
    val4 <= val3;
    zc4  <= zc3;
    n4   <= {20'd0, val3} * {8'd0, b3};

    // Stage 5: quotient estimate.
    sec5 <= sec4;
    val5 <= val4;
    zc5  <= zc4;
    y5   <= n4[27:8];
    q5   <= q_prod[39:32];

    // Stage 6: packed result.
    argb_word <= {ALPHA, red, green, blue};
  end

endmodule

FILE: test/tb_hsv_to_rgb_converter.sv
// Self-checking testbench for the HSV to packed ARGB pixel converter.
module tb_hsv_to_rgb_converter import hsv_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PIXELS = 1000;
  localparam int HUE_LIMIT     = 6 * HUE_SECTOR;
  localparam int SETTLE_CYCLES = 12;

  // One directed pixel; typed rows carry their color, the rest use the predictor.
  typedef struct packed {
    logic [14:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
    logic        typed;
    logic [31:0] argb;
  } pixel_case_t;

  localparam int DIRECTED_COUNT = 21;

  pixel_case_t directed_cases [DIRECTED_COUNT] = '{
    '{15'd0,     8'd0,   8'd0,   1'b1, 32'hFF000000},
    '{15'd0,     8'd255, 8'd0,   1'b1, 32'hFF000000},
    '{15'd12345, 8'd128, 8'd0,   1'b1, 32'hFF000000},
    '{15'd0,     8'd0,   8'd255, 1'b1, 32'hFFFFFFFF},
    '{15'd9000,  8'd0,   8'd255, 1'b1, 32'hFFFFFFFF},
    '{15'd0,     8'd0,   8'd128, 1'b1, 32'hFF808080},
    '{15'd0,     8'd255, 8'd255, 1'b1, 32'hFFFF0000},
    '{15'd3840,  8'd255, 8'd255, 1'b1, 32'hFFFFFF00},
    '{15'd7680,  8'd255, 8'd255, 1'b1, 32'hFF00FF00},
    '{15'd11520, 8'd255, 8'd255, 1'b1, 32'hFF00FFFF},
    '{15'd15360, 8'd255, 8'd255, 1'b1, 32'hFF0000FF},
    '{15'd19200, 8'd255, 8'd255, 1'b1, 32'hFFFF00FF},
    '{15'd3839,  8'd255, 8'd255, 1'b0, 32'h0},
    '{15'd23039, 8'd255, 8'd255, 1'b0, 32'h0},
    '{15'd23040, 8'd255, 8'd255, 1'b0, 32'h0},
    '{15'd32767, 8'd255, 8'd255, 1'b0, 32'h0},
    '{15'd32767, 8'd170, 8'd85,  1'b0, 32'h0},
    '{15'd21845, 8'd85,  8'd170, 1'b0, 32'h0},
    '{15'd10922, 8'd170, 8'd85,  1'b0, 32'h0},
    '{15'd1920,  8'd128, 8'd200, 1'b0, 32'h0},
    '{15'd5759,  8'd1,   8'd254, 1'b0, 32'h0}
  };

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [14:0] hue;
  logic [7:0]  saturation;
  logic [7:0]  brightness;
  logic        done;
  logic [31:0] argb_word;

  // Typed color that travels with a directed request.
  logic        req_typed;
  logic [31:0] req_argb;

  logic [31:0] pending_argb [$];
  logic [31:0] due_argb;
  int          error_count;
  int          accepted_count;
  int          checked_count;
  int          sector_hits [0:8];

  hsv_to_rgb_converter u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .done       (done),
    .argb_word  (argb_word)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Exact integer conversion over the denominator 255 * 3840.
  function automatic logic [31:0] hsv_to_argb(input logic [14:0] h, input logic [7:0] s,
                                              input logic [7:0] v);
    int unsigned sector;
    int unsigned phase;
    int unsigned mid_gap;
    int unsigned ramp;
    int unsigned span;
    int unsigned full;
    longint unsigned x_num;
    logic [7:0] c_chan;
    logic [7:0] x_chan;
    logic [7:0] z_chan;
    logic [7:0] red;
    logic [7:0] grn;
    logic [7:0] blu;
    span    = HUE_SECTOR;
    full    = CHAN_FULL;
    sector  = h / span;
    phase   = h % HUE_PAIR;
    mid_gap = (phase >= span) ? (phase - span) : (span - phase);
    ramp    = span - mid_gap;
    c_chan  = v;
    z_chan  = 8'((int'(v) * (full - s)) / full);
    x_num   = longint'(v) * full * span - longint'(v) * s * (span - ramp);
    x_chan  = 8'(x_num / X_DEN);
    // Hues at or past 360 degrees are not wrapped and land in the last sector.
    case (sector)
      SEC_RED_UP: begin red = c_chan; grn = x_chan; blu = z_chan; end
      SEC_GRN_DN: begin red = x_chan; grn = c_chan; blu = z_chan; end
      SEC_GRN_UP: begin red = z_chan; grn = c_chan; blu = x_chan; end
      SEC_BLU_DN: begin red = z_chan; grn = x_chan; blu = c_chan; end
      SEC_BLU_UP: begin red = x_chan; grn = z_chan; blu = c_chan; end
      default:    begin red = c_chan; grn = z_chan; blu = x_chan; end
    endcase
    return {ALPHA, red, grn, blu};
  endfunction

  // Record each accepted request and compare each strobed result in order.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        pending_argb.push_back(req_typed ? req_argb : hsv_to_argb(hue, saturation, brightness));
        sector_hits[hue / HUE_SECTOR]++;
        accepted_count++;
      end
      if (done) begin
        if (pending_argb.size() == 0) begin
          $error("argb_word: result %h arrived with no request outstanding", argb_word);
          error_count++;
        end else begin
          due_argb = pending_argb.pop_front();
          checked_count++;
          if (argb_word !== due_argb) begin
            $error("argb_word mismatch: expected %h, actual %h", due_argb, argb_word);
            error_count++;
          end
        end
      end
    end
  end

  // Present one request at a falling edge, hold it until taken, then drop start and idle only when gap is above zero.
  task automatic send_pixel(input logic [14:0] h, input logic [7:0] s, input logic [7:0] v,
                            input logic typed, input logic [31:0] argb, input int gap);
    hue        <= h;
    saturation <= s;
    brightness <= v;
    req_typed  <= typed;
    req_argb   <= argb;
    start      <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Hold off new requests until every outstanding result has come back.
  task automatic drain_pipeline();
    start <= 1'b0;
    while (pending_argb.size() != 0) @(negedge clk);
  endtask

  initial begin
    int          gap;
    int          pick;
    bit          burst;
    logic [14:0] h;
    logic [7:0]  s;
    logic [7:0]  v;
    error_count    = 0;
    accepted_count = 0;
    checked_count  = 0;
    foreach (sector_hits[i]) sector_hits[i] = 0;
    rst        <= 1'b1;
    start      <= 1'b0;
    hue        <= '0;
    saturation <= '0;
    brightness <= '0;
    req_typed  <= 1'b0;
    req_argb   <= '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table: extremes, primaries and secondaries, sector edges, wide hues.
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      gap = $urandom_range(0, 19);
      send_pixel(directed_cases[i].hue, directed_cases[i].sat, directed_cases[i].val,
                 directed_cases[i].typed, directed_cases[i].argb, gap);
    end
    drain_pipeline();

    // Random pixels, in blocks that either stream back to back or idle at random.
    burst = 1'b0;
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_PIXELS / 2) drain_pipeline();
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        h = 15'($urandom_range(1, 5) * HUE_SECTOR - 1 + $urandom_range(0, 2));
      end else if (pick < 4) begin
        h = 15'($urandom_range(HUE_LIMIT, 32767));
      end else begin
        h = 15'($urandom_range(0, HUE_LIMIT - 1));
      end
      s = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
                                      : 8'($urandom_range(0, 255));
      v = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 8'd255 : 8'd0)
                                      : 8'($urandom_range(0, 255));
      gap = burst ? 0 : $urandom_range(0, 19);
      send_pixel(h, s, v, 1'b0, 32'h0, gap);
    end

    // Let the pipeline empty and watch for stray results.
    start <= 1'b0;
    while (pending_argb.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Converted %0d pixels (%0d from the directed table), %0d results checked.",
             accepted_count, DIRECTED_COUNT, checked_count);
    $display("Hues per sector 0..5: %0d %0d %0d %0d %0d %0d; at or past 360 degrees: %0d.",
             sector_hits[0], sector_hits[1], sector_hits[2], sector_hits[3],
             sector_hits[4], sector_hits[5],
             sector_hits[6] + sector_hits[7] + sector_hits[8]);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Guard against a hung handshake or results that never arrive.
  initial begin
    #2ms;
    $display("Timed out with %0d results outstanding.", pending_argb.size());
    $display("status: fail");
    $finish;
  end

endmodule

FILE: hsv_to_rgb_converter.f
hdl/hsv_pkg.sv
hdl/hsv_to_rgb_converter.sv
test/tb_hsv_to_rgb_converter.sv
